### sv/aaq_pkg.sv
// Package for the axis-angle to unit quaternion block.
// Holds widths, fixed-point constants, the CORDIC arctangent table and the lane types.
// No dependencies.
package aaq_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int CW           = 34;   // CORDIC x/y/z width
   localparam int PART_W       = 32;   // Q28 quaternion parts
   localparam int MAG_W        = 31;
   localparam int NSQ_W        = 62;   // sum of squares
   localparam int ROOT_W       = NSQ_W / 2;
   localparam int REM_W        = 40;   // square root remainder
   localparam int DIV_W        = ROOT_W + 1;
   localparam int DREM_W       = DIV_W + 1;
   localparam int QUOT_W       = 16;
   localparam int NUM_W        = MAG_W + 16;
   localparam int Q_W          = 16;

   localparam logic [1:0] TYPE_AXIS3  = 2'd0;
   localparam logic [1:0] TYPE_PLANAR = 2'd1;
   localparam logic [1:0] TYPE_ZAXIS  = 2'd2;

   localparam logic signed [31:0] PHASE_SCALE = 32'sd1367130551;
   localparam logic [CW-1:0]      CORDIC_X0   = CW'(652032874);
   localparam logic signed [15:0] ONE_AXIS    = 16'sd16384;
   localparam logic [QUOT_W-1:0]  ONE_Q14     = 16'd16384;

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } aaq_lane_type;

   typedef aaq_lane_type [3:0] aaq_lanes_type;

   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [DREM_W-1:0] rem;
      logic [QUOT_W-1:0] lo;
      logic [QUOT_W-1:0] q;
   } aaq_dlane_type;

   typedef aaq_dlane_type [3:0] aaq_dlanes_type;

   typedef struct packed {
      logic signed [Q_W-1:0] quat_scalar;
      logic signed [Q_W-1:0] quat_i;
      logic signed [Q_W-1:0] quat_j;
      logic signed [Q_W-1:0] quat_k;
      logic                  degenerate;
   } aaq_rsp_type;

endpackage

### sv/aaq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on aaq_pkg.
interface aaq_req_if import aaq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic signed [31:0] angle_rad;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic signed [15:0] axis_z;

   modport source (output valid, req_type, angle_rad, axis_x, axis_y, axis_z, input ready);
   modport sink   (input valid, req_type, angle_rad, axis_x, axis_y, axis_z, output ready);
endinterface

interface aaq_rsp_if import aaq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] quat_scalar;
   logic signed [Q_W-1:0] quat_i;
   logic signed [Q_W-1:0] quat_j;
   logic signed [Q_W-1:0] quat_k;
   logic                  degenerate;

   modport source (output valid, quat_scalar, quat_i, quat_j, quat_k, degenerate, input ready);
   modport sink   (input valid, quat_scalar, quat_i, quat_j, quat_k, degenerate, output ready);
endinterface

### sv/axis_angle_to_unit_quaternion.sv
// Axis-angle to unit quaternion: accepts one request per clock while the output queue is
// not full and returns one unit quaternion per request, in order. The pipeline is 77
// register stages: angle scaling, 24 CORDIC stages, quaternion multiply, squares, sum,
// 31 square root stages, divider setup, 16 divider stages and output formatting. A
// two-entry output queue decouples the result side; the whole pipeline holds only while
// that queue is full, so the sustained rate is one per cycle.
// Depends on aaq_pkg and aaq_if.
module axis_angle_to_unit_quaternion import aaq_pkg::*; (
   input logic         clock,
   input logic         reset,
   aaq_req_if.sink     req_ch,
   aaq_rsp_if.source   rsp_ch
);

   localparam int S_PART  = 1 + CORDIC_STEPS;
   localparam int NSTAGE  = S_PART + 3 + ROOT_W + 1 + QUOT_W + 1;

   logic               en;
   logic [NSTAGE-1:0]  valid_ff;

   // ---------------- angle scaling and axis select ----------------
   logic signed [63:0] prod_in;
   logic signed [15:0] ax_in, ay_in, az_in;
   logic [31:0]        phase_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;

   assign prod_in = req_ch.angle_rad * PHASE_SCALE;

   always_comb begin
      unique case (req_ch.req_type)
         TYPE_AXIS3: begin
            ax_in = req_ch.axis_x;
            ay_in = req_ch.axis_y;
            az_in = req_ch.axis_z;
         end
         TYPE_PLANAR: begin
            ax_in = req_ch.axis_x;
            ay_in = req_ch.axis_y;
            az_in = ONE_AXIS;
         end
         default: begin
            ax_in = '0;
            ay_in = '0;
            az_in = ONE_AXIS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= prod_in[60:29];
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         az_ff    <= az_in;
      end
   end

   // ---------------- CORDIC ----------------
   logic signed [CW-1:0] cx_src [CORDIC_STEPS];
   logic signed [CW-1:0] cy_src [CORDIC_STEPS];
   logic signed [CW-1:0] cz_src [CORDIC_STEPS];
   logic [1:0]           cq_src [CORDIC_STEPS];
   logic signed [15:0]   cax_src [CORDIC_STEPS];
   logic signed [15:0]   cay_src [CORDIC_STEPS];
   logic signed [15:0]   caz_src [CORDIC_STEPS];
   logic signed [CW-1:0] cx_ff [CORDIC_STEPS];
   logic signed [CW-1:0] cy_ff [CORDIC_STEPS];
   logic signed [CW-1:0] cz_ff [CORDIC_STEPS];
   logic [1:0]           cq_ff [CORDIC_STEPS];
   logic signed [15:0]   cax_ff [CORDIC_STEPS];
   logic signed [15:0]   cay_ff [CORDIC_STEPS];
   logic signed [15:0]   caz_ff [CORDIC_STEPS];

   always_comb begin
      cx_src[0]  = $signed(CORDIC_X0);
      cy_src[0]  = '0;
      cz_src[0]  = $signed(CW'(phase_ff[29:0]));
      cq_src[0]  = phase_ff[31:30];
      cax_src[0] = ax_ff;
      cay_src[0] = ay_ff;
      caz_src[0] = az_ff;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         cx_src[i]  = cx_ff[i-1];
         cy_src[i]  = cy_ff[i-1];
         cz_src[i]  = cz_ff[i-1];
         cq_src[i]  = cq_ff[i-1];
         cax_src[i] = cax_ff[i-1];
         cay_src[i] = cay_ff[i-1];
         caz_src[i] = caz_ff[i-1];
      end
   end

   for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en) begin
            if (!cz_src[gi][CW-1]) begin
               cx_ff[gi] <= cx_src[gi] - (cy_src[gi] >>> gi);
               cy_ff[gi] <= cy_src[gi] + (cx_src[gi] >>> gi);
               cz_ff[gi] <= cz_src[gi] - $signed(CW'(ATAN_TURNS[gi]));
            end else begin
               cx_ff[gi] <= cx_src[gi] + (cy_src[gi] >>> gi);
               cy_ff[gi] <= cy_src[gi] - (cx_src[gi] >>> gi);
               cz_ff[gi] <= cz_src[gi] + $signed(CW'(ATAN_TURNS[gi]));
            end
            cq_ff[gi]  <= cq_src[gi];
            cax_ff[gi] <= cax_src[gi];
            cay_ff[gi] <= cay_src[gi];
            caz_ff[gi] <= caz_src[gi];
         end
      end
   end

   // ---------------- quaternion parts in Q28 ----------------
   logic signed [CW-1:0]    cos_v, sin_v;
   logic signed [CW+15:0]   pi_in, pj_in, pk_in;
   logic signed [PART_W-1:0] part_ff [4];

   always_comb begin
      unique case (cq_ff[CORDIC_STEPS-1])
         2'd0: begin
            cos_v = cx_ff[CORDIC_STEPS-1];
            sin_v = cy_ff[CORDIC_STEPS-1];
         end
         2'd1: begin
            cos_v = -cy_ff[CORDIC_STEPS-1];
            sin_v = cx_ff[CORDIC_STEPS-1];
         end
         2'd2: begin
            cos_v = -cx_ff[CORDIC_STEPS-1];
            sin_v = -cy_ff[CORDIC_STEPS-1];
         end
         default: begin
            cos_v = cy_ff[CORDIC_STEPS-1];
            sin_v = -cx_ff[CORDIC_STEPS-1];
         end
      endcase
      pi_in = sin_v * cax_ff[CORDIC_STEPS-1];
      pj_in = sin_v * cay_ff[CORDIC_STEPS-1];
      pk_in = sin_v * caz_ff[CORDIC_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         part_ff[0] <= PART_W'(cos_v >>> 2);
         part_ff[1] <= PART_W'(pi_in >>> 16);
         part_ff[2] <= PART_W'(pj_in >>> 16);
         part_ff[3] <= PART_W'(pk_in >>> 16);
      end
   end

   // ---------------- squares and sum ----------------
   aaq_lanes_type    lane_in, lane_ff, sum_lane_ff;
   logic [NSQ_W-1:0] sq_ff [4];
   logic [NSQ_W-1:0] nsq_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lane_in[i].neg = part_ff[i][PART_W-1];
         lane_in[i].mag = part_ff[i][PART_W-1] ? MAG_W'(-part_ff[i]) : MAG_W'(part_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= NSQ_W'(lane_in[i].mag) * NSQ_W'(lane_in[i].mag);
         end
         sum_lane_ff <= lane_ff;
         nsq_ff      <= sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
      end
   end

   // ---------------- square root, one root bit per stage ----------------
   logic [REM_W-1:0]  sr_rem_src [ROOT_W];
   logic [ROOT_W-1:0] sr_root_src [ROOT_W];
   logic [NSQ_W-1:0]  sr_nsq_src [ROOT_W];
   aaq_lanes_type     sr_lane_src [ROOT_W];
   logic [REM_W-1:0]  sr_rem_ff [ROOT_W];
   logic [ROOT_W-1:0] sr_root_ff [ROOT_W];
   logic [NSQ_W-1:0]  sr_nsq_ff [ROOT_W];
   aaq_lanes_type     sr_lane_ff [ROOT_W];

   always_comb begin
      sr_rem_src[0]  = '0;
      sr_root_src[0] = '0;
      sr_nsq_src[0]  = nsq_ff;
      sr_lane_src[0] = sum_lane_ff;
      for (int i = 1; i < ROOT_W; i++) begin
         sr_rem_src[i]  = sr_rem_ff[i-1];
         sr_root_src[i] = sr_root_ff[i-1];
         sr_nsq_src[i]  = sr_nsq_ff[i-1];
         sr_lane_src[i] = sr_lane_ff[i-1];
      end
   end

   for (genvar gj = 0; gj < ROOT_W; gj++) begin : g_sqrt
      logic [REM_W-1:0] t;
      logic [REM_W-1:0] trial;
      assign t     = {sr_rem_src[gj][REM_W-3:0], sr_nsq_src[gj][NSQ_W-1-2*gj -: 2]};
      assign trial = {(REM_W-ROOT_W-2)'(0), sr_root_src[gj], 2'b01};
      always_ff @(posedge clock) begin
         if (en) begin
            if (t >= trial) begin
               sr_rem_ff[gj]  <= t - trial;
               sr_root_ff[gj] <= {sr_root_src[gj][ROOT_W-2:0], 1'b1};
            end else begin
               sr_rem_ff[gj]  <= t;
               sr_root_ff[gj] <= {sr_root_src[gj][ROOT_W-2:0], 1'b0};
            end
            sr_nsq_ff[gj]  <= sr_nsq_src[gj];
            sr_lane_ff[gj] <= sr_lane_src[gj];
         end
      end
   end

   // ---------------- divider setup and 16 quotient stages ----------------
   logic [ROOT_W-1:0] root_v;
   logic [DIV_W-1:0]  dsr_in;
   aaq_dlanes_type    dp_in;
   aaq_dlanes_type    dv_ff [QUOT_W+1];
   logic [DIV_W-1:0]  d_ff [QUOT_W+1];
   logic              dg_ff [QUOT_W+1];

   assign root_v = sr_root_ff[ROOT_W-1];
   assign dsr_in = {root_v, 1'b0};

   always_comb begin
      logic [NUM_W-1:0] num;
      num = '0;
      for (int i = 0; i < 4; i++) begin
         num = (NUM_W'(sr_lane_ff[ROOT_W-1][i].mag) << 15) + NUM_W'(root_v);
         dp_in[i].neg = sr_lane_ff[ROOT_W-1][i].neg;
         dp_in[i].ovf = {1'b0, num} >= {dsr_in, 16'b0};
         dp_in[i].rem = dp_in[i].ovf ? '0 : DREM_W'(num[NUM_W-1:16]);
         dp_in[i].lo  = num[15:0];
         dp_in[i].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dp_in;
         d_ff[0]  <= dsr_in;
         dg_ff[0] <= (root_v == '0);
      end
   end

   for (genvar gk = 1; gk <= QUOT_W; gk++) begin : g_div
      for (genvar gl = 0; gl < 4; gl++) begin : g_lane
         logic [DREM_W-1:0] t;
         logic              ge;
         assign t  = {dv_ff[gk-1][gl].rem[DREM_W-2:0], dv_ff[gk-1][gl].lo[QUOT_W-gk]};
         assign ge = t >= {1'b0, d_ff[gk-1]};
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[gk][gl].neg <= dv_ff[gk-1][gl].neg;
               dv_ff[gk][gl].ovf <= dv_ff[gk-1][gl].ovf;
               dv_ff[gk][gl].lo  <= dv_ff[gk-1][gl].lo;
               dv_ff[gk][gl].rem <= ge ? (t - {1'b0, d_ff[gk-1]}) : t;
               dv_ff[gk][gl].q   <= {dv_ff[gk-1][gl].q[QUOT_W-2:0], ge};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[gk]  <= d_ff[gk-1];
            dg_ff[gk] <= dg_ff[gk-1];
         end
      end
   end

   // ---------------- output formatting ----------------
   logic [Q_W-1:0] qv [4];
   logic [Q_W-1:0] qs [4];
   aaq_rsp_type    out_in, out_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qv[i] = (dv_ff[QUOT_W][i].ovf || dv_ff[QUOT_W][i].q > ONE_Q14) ?
                 ONE_Q14 : dv_ff[QUOT_W][i].q;
         qs[i] = dg_ff[QUOT_W] ? '0 : (dv_ff[QUOT_W][i].neg ? (-qv[i]) : qv[i]);
      end
      out_in.quat_scalar = $signed(qs[0]);
      out_in.quat_i      = $signed(qs[1]);
      out_in.quat_j      = $signed(qs[2]);
      out_in.quat_k      = $signed(qs[3]);
      out_in.degenerate  = dg_ff[QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   // ---------------- valid chain and output queue ----------------
   aaq_rsp_type oq_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign en     = (cnt_ff != 2'd2);
   assign push   = en && valid_ff[NSTAGE-1];
   assign pop    = (cnt_ff != 2'd0) && rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[NSTAGE-2:0], req_ch.valid};
         end
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[wr_ff] <= out_ff;
      end
   end

   assign rsp_ch.valid       = (cnt_ff != 2'd0);
   assign rsp_ch.quat_scalar = oq_ff[rd_ff].quat_scalar;
   assign rsp_ch.quat_i      = oq_ff[rd_ff].quat_i;
   assign rsp_ch.quat_j      = oq_ff[rd_ff].quat_j;
   assign rsp_ch.quat_k      = oq_ff[rd_ff].quat_k;
   assign rsp_ch.degenerate  = oq_ff[rd_ff].degenerate;

   // ---------------- assertions ----------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while held");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |->
         rsp_ch.quat_scalar == '0 && rsp_ch.quat_i == '0 &&
         rsp_ch.quat_j == '0 && rsp_ch.quat_k == '0)
      else $error("degenerate result with nonzero parts");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.quat_scalar <= 16'sd16384 && rsp_ch.quat_scalar >= -16'sd16384)
      else $error("scalar part beyond unit range");

endmodule

### verif/tb_axis_angle_to_unit_quaternion.sv
// Testbench for axis_angle_to_unit_quaternion: random and corner-case angle/axis requests,
// results predicted by a bit-accurate CORDIC, square root and rounding model and checked in order.
// Depends on aaq_pkg, aaq_if and the block itself.
`timescale 1ns / 1ps
module tb_axis_angle_to_unit_quaternion;
   import aaq_pkg::*;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] angle_rad;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } rot_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aaq_req_if req_ch ();
   aaq_rsp_if rsp_ch ();

   axis_angle_to_unit_quaternion i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rot_req_type pending_reqs[$];
   aaq_rsp_type expected_quats[$];
   int mismatch_count = 0;
   int checked_count = 0;
   int degenerate_count = 0;
   bit hold_sender = 1'b0;
   bit in_fire = 1'b0;
   int long_stall = 0;
   int burst_left = 0;
   int gap_left = 0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [15:0] unit_q14(longint part, longint root);
      longint mag;
      longint q;
      mag = (part < 0) ? -part : part;
      q = (mag * 32768 + root) / (2 * root);
      if (q > 16384) q = 16384;
      return (part < 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic longint isqrt(longint n);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic aaq_rsp_type predict_quat(rot_req_type rq);
      longint ang, ax, ay, az, x, y, z, dx, dy, c, s, nsq, root, tmp;
      logic [63:0] prod;
      logic [31:0] phase;
      longint part[4];
      aaq_rsp_type r;
      ang = longint'(rq.angle_rad);
      ax = longint'(rq.axis_x);
      ay = longint'(rq.axis_y);
      az = longint'(rq.axis_z);
      prod = 64'(ang * 64'sd1367130551);
      phase = prod[60:29];
      z = longint'({2'b00, phase[29:0]});
      x = 64'sd652032874;
      y = 0;
      if (rq.req_type == TYPE_PLANAR) begin
         az = 16384;
      end else if (rq.req_type != TYPE_AXIS3) begin
         ax = 0;
         ay = 0;
         az = 16384;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TURNS[i]);
         end
      end
      case (phase[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      part[0] = floor_shr(c, 2);
      part[1] = floor_shr(s * ax, 16);
      part[2] = floor_shr(s * ay, 16);
      part[3] = floor_shr(s * az, 16);
      nsq = 0;
      for (int i = 0; i < 4; i++) begin
         tmp = (part[i] < 0) ? -part[i] : part[i];
         nsq = nsq + tmp * tmp;
      end
      r = '0;
      if (nsq == 0) begin
         r.degenerate = 1'b1;
      end else begin
         root = isqrt(nsq);
         r.quat_scalar = unit_q14(part[0], root);
         r.quat_i = unit_q14(part[1], root);
         r.quat_j = unit_q14(part[2], root);
         r.quat_k = unit_q14(part[3], root);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 64)) - 16'sd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'($urandom_range(0, 64)) - 32'sd32;
         // near multiples of pi (those beyond +-5pi wrap), where sin or cos of the half angle nears zero
         3: return 32'(longint'($urandom_range(0, 40)) * 421657428 / 1 - 64'sd8433148560)
                  + 32'($urandom_range(0, 8)) - 32'sd4;
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic rot_req_type mk_req(logic [1:0] t, logic signed [31:0] a,
                                          logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] zc);
      rot_req_type rq;
      rq.req_type = t;
      rq.angle_rad = a;
      rq.axis_x = x;
      rq.axis_y = y;
      rq.axis_z = zc;
      return rq;
   endfunction

   // request transfer seen at the rising edge
   always @(posedge clock) begin
      in_fire <= !reset && req_ch.valid && req_ch.ready;
   end

   // driver: bursts and gaps, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (in_fire) begin
            expected_quats.push_back(predict_quat(pending_reqs.pop_front()));
         end
         if (gap_left > 0) gap_left = gap_left - 1;
         if (!(req_ch.valid && !in_fire) && burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
         if (req_ch.valid && !in_fire) begin
            req_ch.valid <= 1'b1;
         end else if (pending_reqs.size() > 0 && !hold_sender && gap_left == 0 && burst_left > 0) begin
            burst_left = burst_left - 1;
            req_ch.valid <= 1'b1;
            {req_ch.req_type, req_ch.angle_rad, req_ch.axis_x, req_ch.axis_y, req_ch.axis_z}
               <= pending_reqs[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, plus one long hold-off
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 23;
      if (long_stall > 0) begin
         long_stall = long_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_phase < 7) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      aaq_rsp_type got, exp_q;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.quat_scalar = rsp_ch.quat_scalar;
         got.quat_i = rsp_ch.quat_i;
         got.quat_j = rsp_ch.quat_j;
         got.quat_k = rsp_ch.quat_k;
         got.degenerate = rsp_ch.degenerate;
         if (expected_quats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer %p", got);
         end else begin
            exp_q = expected_quats.pop_front();
            checked_count++;
            if (exp_q.degenerate) degenerate_count++;
            if (got != exp_q) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch #%0d: expected %p, got %p", checked_count, exp_q, got);
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.angle_rad = '0;
      req_ch.axis_x = '0;
      req_ch.axis_y = '0;
      req_ch.axis_z = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd0, 16'sd16384, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd0, 16'sd0, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd421657428, 16'sd0, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sh8000_0000, 16'sh8000, 16'sh8000, 16'sh8000));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd421657428, 16'sd1, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd421657428, 16'sd1, 16'sh8000, 16'sd1));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd843314856, 16'sd1, 16'sd1, 16'sd1));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, -32'sd210828714, 16'sd9459, -16'sd9459, 16'sd9459));
      pending_reqs.push_back(mk_req(TYPE_PLANAR, 32'sd210828714, 16'sd16384, 16'sd0, 16'sh7FFF));
      pending_reqs.push_back(mk_req(TYPE_PLANAR, 32'sh8000_0000, 16'sh8000, 16'sh7FFF, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_PLANAR, 32'sd421657428, 16'sd0, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_ZAXIS, 32'sd421657428, 16'sh7FFF, 16'sh8000, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_ZAXIS, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(2'd3, 32'sd105414357, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      pending_reqs.push_back(mk_req(2'd3, -32'sd1, 16'sd0, 16'sd0, 16'sd0));
      pending_reqs.push_back(mk_req(TYPE_AXIS3, 32'sd1, 16'sh7FFF, 16'sd0, 16'sd0));

      // pause until drained
      while (pending_reqs.size() != 0) @(posedge clock);
      hold_sender = 1'b1;
      while (expected_quats.size() != 0 || req_ch.valid) @(posedge clock);
      hold_sender = 1'b0;

      // long receiver hold-off while the pipeline fills
      long_stall = 300;
      for (int n = 0; n < 1700; n++) begin
         logic [1:0] t;
         t = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         pending_reqs.push_back(mk_req(t, rand_angle(), rand_axis(), rand_axis(), rand_axis()));
         if (n % 200 == 199) begin
            while (pending_reqs.size() >= 50) @(posedge clock);
         end
      end
      while (pending_reqs.size() != 0) @(posedge clock);
      while (expected_quats.size() != 0 || req_ch.valid) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("checked %0d quaternion results (%0d degenerate) over all axis forms,",
               checked_count, degenerate_count);
      $display("with random sender bursts, receiver stalls and one long output hold-off");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", expected_quats.size());
      $display("end of test: mismatches");
      $finish;
   end
endmodule
